@@ rtl/swsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader package
// Shared types, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package swsr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_LOW  = 3'd0;
    localparam logic [2:0] REG_START_HIGH = 3'd1;
    localparam logic [2:0] REG_RESP_LOW   = 3'd2;
    localparam logic [2:0] REG_RESP_HIGH  = 3'd3;
    localparam logic [2:0] REG_RESP_TAIL  = 3'd4;
    localparam logic [2:0] REG_BIT_SAMPLE = 3'd5;
    localparam logic [2:0] REG_BYTE_COUNT = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_START_LOW  = 16'd18000;
    localparam logic [7:0]  RST_START_HIGH = 8'd30;
    localparam logic [7:0]  RST_RESP_LOW   = 8'd40;
    localparam logic [7:0]  RST_RESP_HIGH  = 8'd80;
    localparam logic [7:0]  RST_RESP_TAIL  = 8'd40;
    localparam logic [7:0]  RST_BIT_SAMPLE = 8'd30;
    localparam logic [3:0]  RST_BYTE_COUNT = 4'd5;

    // Largest number of bytes in one transaction.
    localparam logic [3:0]  MAX_BYTES = 4'd8;

    // Event codes on the result channel.
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_OK   = 2'd1;
    localparam logic [1:0] EV_FAIL = 2'd2;
    localparam logic [1:0] EV_BYTE = 2'd3;

    // Transaction phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE       = 9'b000000001,
        PH_START_LOW  = 9'b000000010,
        PH_START_HIGH = 9'b000000100,
        PH_RESP_LOW   = 9'b000001000,
        PH_RESP_HIGH  = 9'b000010000,
        PH_TAIL       = 9'b000100000,
        PH_WAIT_HIGH  = 9'b001000000,
        PH_SAMPLE     = 9'b010000000,
        PH_WAIT_LOW   = 9'b100000000
    } t_phase;

    // One result word as it sits in the output stage.
    typedef struct packed {
        logic       drive_enable;
        logic       drive_value;
        logic [1:0] event_res;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       busy_res;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/single_wire_sensor_reader_unit.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader
// Master for a one-wire humidity or temperature sensor, stepped by words.
// ----------------------------------------------------------------------------
//
// Each input word is either a one-microsecond tick or a start command, and
// carries the sampled level of the data line. Every accepted word produces
// exactly one result word that shows the line drive, any event (response
// ok, response failed, data byte) and the busy flag after that step. The
// block takes one word per clock cycle while s_tready is high; each result
// is registered. The whole step is a single pass of logic from the phase
// register and the one 16-bit timer compare into a two-entry output stage,
// so a stalled result channel costs nothing until both entries are full,
// at which point s_tready drops until the master side drains a word.
// The user writes configuration registers through the plain write port
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module single_wire_sensor_reader_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,

    // Input word channel.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [0] line_level, [7:1] zero
    input  wire logic        i_s_tuser,   // [0] cmd (1 = start)

    // Result word channel.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [0] drive_enable, [1] drive_value,
                                          // [9:2] data_byte, [10] busy_res,
                                          // [15:11] zero
    output logic [1:0]       o_m_tuser,   // [1:0] event_res
    output logic             o_m_tlast    // last_byte
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0] r_start_low;
    logic [7:0]  r_start_high;
    logic [7:0]  r_resp_low;
    logic [7:0]  r_resp_high;
    logic [7:0]  r_resp_tail;
    logic [7:0]  r_bit_sample;
    logic [3:0]  r_byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low  <= swsr_pkg::RST_START_LOW;
            r_start_high <= swsr_pkg::RST_START_HIGH;
            r_resp_low   <= swsr_pkg::RST_RESP_LOW;
            r_resp_high  <= swsr_pkg::RST_RESP_HIGH;
            r_resp_tail  <= swsr_pkg::RST_RESP_TAIL;
            r_bit_sample <= swsr_pkg::RST_BIT_SAMPLE;
            r_byte_count <= swsr_pkg::RST_BYTE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                swsr_pkg::REG_START_LOW:  r_start_low  <= i_cfg_wdata;
                swsr_pkg::REG_START_HIGH: r_start_high <= i_cfg_wdata[7:0];
                swsr_pkg::REG_RESP_LOW:   r_resp_low   <= i_cfg_wdata[7:0];
                swsr_pkg::REG_RESP_HIGH:  r_resp_high  <= i_cfg_wdata[7:0];
                swsr_pkg::REG_RESP_TAIL:  r_resp_tail  <= i_cfg_wdata[7:0];
                swsr_pkg::REG_BIT_SAMPLE: r_bit_sample <= i_cfg_wdata[7:0];
                swsr_pkg::REG_BYTE_COUNT: r_byte_count <= i_cfg_wdata[3:0];
                default: ;  // Writes beyond the register list are dropped.
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Transaction state.
    // ------------------------------------------------------------------
    swsr_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_tick, n_tick;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_shift, n_shift;
    logic [3:0]       r_bytes, n_bytes;

    logic             w_accept;
    logic             w_cmd;
    logic             w_line;
    logic [15:0]      w_tick_inc;
    logic [15:0]      w_target;
    logic             w_wait_done;
    logic [3:0]       w_want;
    logic [3:0]       w_bytes_inc;
    logic [2:0]       w_bit_inc;
    logic [7:0]       w_shift_in;
    logic [1:0]       w_event;
    logic [7:0]       w_data;
    logic             w_last;
    swsr_pkg::t_result w_result;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_cmd    = i_s_tuser;
    assign w_line   = i_s_tdata[0];

    // The timer counts up and a wait ends on the tick at which it reaches
    // the length of the current phase; only one length is live at a time.
    always_comb begin
        unique case (r_phase)
            swsr_pkg::PH_START_LOW:  w_target = r_start_low;
            swsr_pkg::PH_START_HIGH: w_target = {8'd0, r_start_high};
            swsr_pkg::PH_RESP_LOW:   w_target = {8'd0, r_resp_low};
            swsr_pkg::PH_RESP_HIGH:  w_target = {8'd0, r_resp_high};
            swsr_pkg::PH_TAIL:       w_target = {8'd0, r_resp_tail};
            swsr_pkg::PH_SAMPLE:     w_target = {8'd0, r_bit_sample};
            default:                 w_target = 16'd0;
        endcase
    end

    assign w_tick_inc  = r_tick + 16'd1;
    assign w_wait_done = (w_tick_inc >= w_target);

    // A byte count of zero reads as one, anything above eight as eight.
    always_comb begin
        priority if (r_byte_count == 4'd0) begin
            w_want = 4'd1;
        end else if (r_byte_count > swsr_pkg::MAX_BYTES) begin
            w_want = swsr_pkg::MAX_BYTES;
        end else begin
            w_want = r_byte_count;
        end
    end

    assign w_bytes_inc = r_bytes + 4'd1;
    assign w_bit_inc   = r_bit_idx + 3'd1;
    assign w_shift_in  = {r_shift[6:0], w_line};

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        w_event   = swsr_pkg::EV_NONE;
        w_data    = 8'd0;
        w_last    = 1'b0;

        unique case (r_phase)
            swsr_pkg::PH_IDLE: begin
                // The start word itself is not counted as a tick.
                if (w_cmd) begin
                    n_phase   = swsr_pkg::PH_START_LOW;
                    n_tick    = 16'd0;
                    n_bit_idx = 3'd0;
                    n_shift   = 8'd0;
                    n_bytes   = 4'd0;
                end
            end
            swsr_pkg::PH_START_LOW: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    n_phase = swsr_pkg::PH_START_HIGH;
                end
            end
            swsr_pkg::PH_START_HIGH: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    n_phase = swsr_pkg::PH_RESP_LOW;
                end
            end
            swsr_pkg::PH_RESP_LOW: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    if (!w_line) begin
                        n_phase = swsr_pkg::PH_RESP_HIGH;
                    end else begin
                        w_event = swsr_pkg::EV_FAIL;
                        n_phase = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_RESP_HIGH: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    if (w_line) begin
                        w_event = swsr_pkg::EV_OK;
                        n_phase = (r_resp_tail == 8'd0) ? swsr_pkg::PH_WAIT_HIGH
                                                        : swsr_pkg::PH_TAIL;
                    end else begin
                        w_event = swsr_pkg::EV_FAIL;
                        n_phase = swsr_pkg::PH_IDLE;
                    end
                end
            end
            swsr_pkg::PH_TAIL: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    n_phase = swsr_pkg::PH_WAIT_HIGH;
                end
            end
            swsr_pkg::PH_WAIT_HIGH: begin
                if (w_line) begin
                    n_phase = swsr_pkg::PH_SAMPLE;
                    n_tick  = 16'd0;
                end
            end
            swsr_pkg::PH_SAMPLE: begin
                n_tick = w_wait_done ? 16'd0 : w_tick_inc;
                if (w_wait_done) begin
                    n_shift   = w_shift_in;
                    n_bit_idx = w_bit_inc;
                    n_phase   = w_line ? swsr_pkg::PH_WAIT_LOW : swsr_pkg::PH_WAIT_HIGH;
                    if (w_bit_inc == 3'd0) begin
                        // Eighth bit of a byte: hand it out and start afresh.
                        w_event = swsr_pkg::EV_BYTE;
                        w_data  = w_shift_in;
                        n_bytes = w_bytes_inc;
                        n_shift = 8'd0;
                        if (w_bytes_inc >= w_want) begin
                            w_last  = 1'b1;
                            n_phase = swsr_pkg::PH_IDLE;
                        end
                    end
                end
            end
            swsr_pkg::PH_WAIT_LOW: begin
                if (!w_line) begin
                    n_phase = swsr_pkg::PH_WAIT_HIGH;
                end
            end
            default: begin
                n_phase = swsr_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= swsr_pkg::PH_IDLE;
            r_tick    <= 16'd0;
            r_bit_idx <= 3'd0;
            r_shift   <= 8'd0;
            r_bytes   <= 4'd0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
        end
    end

    // Result word reflects the phase after the step.
    assign w_result.drive_enable = (n_phase == swsr_pkg::PH_START_LOW) ||
                                   (n_phase == swsr_pkg::PH_START_HIGH);
    assign w_result.drive_value  = (n_phase == swsr_pkg::PH_START_HIGH);
    assign w_result.event_res    = w_event;
    assign w_result.data_byte    = w_data;
    assign w_result.last_byte    = w_last;
    assign w_result.busy_res     = (n_phase != swsr_pkg::PH_IDLE);

    // ------------------------------------------------------------------
    // Two-entry output stage: the main register feeds the port, the skid
    // register catches a word accepted while the main one is stalled.
    // ------------------------------------------------------------------
    swsr_pkg::t_result r_out, r_skid;
    logic              r_out_valid, r_skid_valid;
    logic              w_take;

    assign w_take     = r_out_valid && i_m_tready;
    assign o_s_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            if (!r_out_valid) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.busy_res, r_out.data_byte,
                         r_out.drive_value, r_out.drive_enable};
    assign o_m_tuser  = r_out.event_res;
    assign o_m_tlast  = r_out.last_byte;

endmodule

`default_nettype wire

@@ rtl/swsr_checker.sv @@
// ----------------------------------------------------------------------------
// Single-wire sensor reader checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swsr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic [1:0]  o_m_tuser,
    input wire logic        o_m_tlast
);

    // A high drive level is only ever shown while the line is driven.
    a_drive_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1]) |-> o_m_tdata[0])
        else $error("drive value high while line released");

    // Driving the line happens only inside a transaction.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> o_m_tdata[10])
        else $error("line driven while not busy");

    // The final byte carries a byte event and ends the transaction.
    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |->
            (o_m_tuser == swsr_pkg::EV_BYTE) && !o_m_tdata[10])
        else $error("last flag without final byte event");

    // A stalled result word holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

endmodule

bind single_wire_sensor_reader_unit swsr_checker u_swsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
